// ===== src/smf_pkg.sv =====
// Shared constants and types of the SPI master with byte FIFOs.
`timescale 1ns / 1ps
package smf_pkg;

   localparam int FIFO_DEPTH = 64;
   localparam int ADDR_W     = $clog2(FIFO_DEPTH);
   localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);
   localparam int CTL_W      = 19;
   localparam int CLK_W      = 13;
   localparam int COUNT_W    = 24;
   localparam int DIV_W      = 16;

   // Item kinds carried in tuser
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   // Register byte offsets
   localparam logic [5:0] REG_RX_DATA  = 6'h00;
   localparam logic [5:0] REG_TX_DATA  = 6'h04;
   localparam logic [5:0] REG_CONTROL  = 6'h08;
   localparam logic [5:0] REG_IRQ_EN   = 6'h0c;
   localparam logic [5:0] REG_IRQ_STAT = 6'h10;
   localparam logic [5:0] REG_CLOCK    = 6'h1c;
   localparam logic [5:0] REG_BURST    = 6'h20;
   localparam logic [5:0] REG_TRANSMIT = 6'h24;
   localparam logic [5:0] REG_FIFO_STAT = 6'h28;

   // Control, IRQ status and clock register bit positions
   localparam int CTL_CPHA      = 2;
   localparam int CTL_CPOL      = 3;
   localparam int CTL_CS_LOW    = 4;
   localparam int CTL_LSB       = 6;
   localparam int CTL_TF_RST    = 8;
   localparam int CTL_RF_RST    = 9;
   localparam int CTL_XCH       = 10;
   localparam int CTL_CS_LO     = 12;
   localparam int CTL_DHB       = 15;
   localparam int CTL_CS_MANUAL = 16;
   localparam int CTL_CS_LEVEL  = 17;
   localparam int STA_TC        = 16;
   localparam int CLK_DRS       = 12;

   typedef struct packed {
      logic       busy;
      logic       cpol;
      logic       cpha;
      logic       lsb;
      logic       cs_low;
      logic       cs_manual;
      logic       cs_level;
      logic [1:0] cs_sel;
      logic       phase;
      logic [2:0] bit_idx;
      logic [7:0] shift;
   } smf_line_state_type;

   typedef struct packed {
      logic       sclk;
      logic       mosi;
      logic [3:0] cs;
   } smf_pins_type;

endpackage

// ===== src/smf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module smf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/smf_pins.sv =====
// Serial line drivers: SCLK, MOSI and chip selects from the engine state.
`timescale 1ns / 1ps
module smf_pins (
   input  smf_pkg::smf_line_state_type line_state,
   output smf_pkg::smf_pins_type        pins
);

   logic [2:0] bitnum;
   logic       active;

   always_comb begin
      pins.sclk = line_state.cpol ^ (line_state.busy & line_state.phase);
      bitnum = line_state.bit_idx;
      if (line_state.cpha && !line_state.phase && bitnum != 3'd0) begin
         bitnum = bitnum - 3'd1;
      end
      if (!line_state.busy) begin
         pins.mosi = 1'b0;
      end else if (line_state.lsb) begin
         pins.mosi = line_state.shift[bitnum];
      end else begin
         pins.mosi = line_state.shift[3'd7 - bitnum];
      end
      pins.cs = line_state.cs_low ? 4'hf : 4'h0;
      if (line_state.cs_manual) begin
         active = line_state.cs_level;
      end else begin
         active = line_state.busy ? ~line_state.cs_low : line_state.cs_low;
      end
      pins.cs[line_state.cs_sel] = active;
   end

endmodule

// ===== src/spi_master_fifo_controller_unit.sv =====
// Top level of the SPI master with TX and RX byte FIFOs held in RAM.
//
//  channel | dir | payload
//  req     | in  | tuser: mode; tdata: address, write_data, miso
//  rsp     | out | tdata: read_data, sclk, mosi, chip_selects, irq, busy_res
//
// One beat is accepted per cycle while req_tready is high; its result beat is held
// in the response register, which also carries the FIFO RAM read data.
// req_tready is low only while a result beat waits and rsp_tready is low.
// Synchronous reset clears all control state; FIFO RAM contents are left
// undefined and are never read before written.
`timescale 1ns / 1ps
module spi_master_fifo_controller_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // mode[1:0]
   input  logic [39:0] req_tdata,  // address[5:0], write_data[37:6], miso[38], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // read_data[31:0], sclk[32], mosi[33],
                                   // chip_selects[37:34], irq[38], busy_res[39]
);

   localparam int DEPTH = smf_pkg::FIFO_DEPTH;
   localparam int AW    = smf_pkg::ADDR_W;
   localparam int LW    = smf_pkg::LEVEL_W;

   logic [smf_pkg::CTL_W-1:0]   control_ff, control_in;
   logic [31:0]                 irq_enable_ff, irq_enable_in;
   logic                        tc_ff, tc_in;
   logic [smf_pkg::CLK_W-1:0]   clock_ctl_ff, clock_ctl_in;
   logic [smf_pkg::COUNT_W-1:0] burst_ff, burst_in;
   logic [smf_pkg::COUNT_W-1:0] transmit_ff, transmit_in;
   logic [smf_pkg::COUNT_W-1:0] done_ff, done_in;
   logic                        shift_ram_ff, shift_ram_in;
   logic [3:0]                  bit_ff, bit_in;
   logic [smf_pkg::DIV_W-1:0]   div_ff, div_in;
   logic                        phase_ff, phase_in;
   logic [7:0]                  gather_ff, gather_in;
   logic [LW-1:0]               tx_level_ff, tx_level_in, rx_level_ff, rx_level_in;
   logic [AW-1:0]               tx_head_ff, tx_head_in, rx_head_ff, rx_head_in;
   logic                        out_valid_ff, out_valid_in;
   logic [31:0]                 rdata_ff, rdata_in;
   logic                        rdata_ram_ff, rdata_ram_in;

   logic          tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;
   logic [AW-1:0] tx_wr_addr, rx_wr_addr;
   logic [7:0]    tx_wr_data, tx_q, rx_q, rx_wr_data;

   logic [1:0]  mode;
   logic [5:0]  address;
   logic [31:0] wdata;
   logic        miso;
   logic        accept;

   smf_pkg::smf_line_state_type line_state;
   smf_pkg::smf_pins_type       pins;

   assign mode    = req_tuser;
   assign address = req_tdata[5:0];
   assign wdata   = req_tdata[37:6];
   assign miso    = req_tdata[38];

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] head,
                                              input logic [LW-1:0] level);
      logic [LW:0] sum;
      sum = {{(LW+1-AW){1'b0}}, head} + {1'b0, level};
      if (sum >= (LW+1)'(DEPTH)) begin
         sum = sum - (LW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] head);
      logic [AW-1:0] r;
      if ({1'b0, head} == (AW+1)'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = head + AW'(1);
      end
      return r;
   endfunction

   always_comb begin
      logic [smf_pkg::CTL_W-1:0]   v;
      logic [smf_pkg::DIV_W:0]     half;
      logic [smf_pkg::DIV_W:0]     div_next;
      logic                        do_next;
      logic                        edge_sample;
      logic [smf_pkg::COUNT_W-1:0] next_done;

      control_in    = control_ff;
      irq_enable_in = irq_enable_ff;
      tc_in         = tc_ff;
      clock_ctl_in  = clock_ctl_ff;
      burst_in      = burst_ff;
      transmit_in   = transmit_ff;
      done_in       = done_ff;
      shift_ram_in  = shift_ram_ff;
      bit_in        = bit_ff;
      div_in        = div_ff;
      phase_in      = phase_ff;
      gather_in     = gather_ff;
      tx_level_in   = tx_level_ff;
      tx_head_in    = tx_head_ff;
      rx_level_in   = rx_level_ff;
      rx_head_in    = rx_head_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      rdata_in      = rdata_ff;
      rdata_ram_in  = rdata_ram_ff;
      tx_wr_en      = 1'b0;
      tx_wr_addr    = wrap_add(tx_head_ff, tx_level_ff);
      tx_wr_data    = wdata[7:0];
      tx_rd_en      = 1'b0;
      rx_wr_en      = 1'b0;
      rx_wr_addr    = wrap_add(rx_head_ff, rx_level_ff);
      rx_wr_data    = '0;
      rx_rd_en      = 1'b0;
      v             = wdata[smf_pkg::CTL_W-1:0];
      half          = '0;
      div_next      = '0;
      do_next       = 1'b0;
      edge_sample   = 1'b0;
      next_done     = done_ff;

      if (accept) begin
         out_valid_in = 1'b1;
         rdata_in     = '0;
         rdata_ram_in = 1'b0;
         case (mode)
            smf_pkg::MODE_TICK: begin
               if (control_ff[smf_pkg::CTL_XCH]) begin
                  if (clock_ctl_ff[smf_pkg::CLK_DRS]) begin
                     half = (smf_pkg::DIV_W+1)'(clock_ctl_ff[7:0]) + 1'b1;
                  end else begin
                     half = (smf_pkg::DIV_W+1)'(1) << clock_ctl_ff[11:8];
                  end
                  div_next = {1'b0, div_ff} + 1'b1;
                  div_in   = div_next[smf_pkg::DIV_W-1:0];
                  if (div_next >= half) begin
                     div_in = '0;
                     if (!phase_ff) begin
                        phase_in    = 1'b1;
                        edge_sample = !control_ff[smf_pkg::CTL_CPHA];
                     end else begin
                        phase_in    = 1'b0;
                        edge_sample = control_ff[smf_pkg::CTL_CPHA];
                     end
                     if (edge_sample) begin
                        gather_in = control_ff[smf_pkg::CTL_LSB] ?
                                    {miso, gather_ff[7:1]} : {gather_ff[6:0], miso};
                     end
                     if (phase_ff) begin
                        bit_in = bit_ff + 4'd1;
                        if (bit_ff == 4'd7) begin
                           // byte complete: keep it unless dropped in the TX phase or the RX FIFO is full
                           if (!(control_ff[smf_pkg::CTL_DHB] && done_ff < transmit_ff)
                               && rx_level_ff < LW'(DEPTH)) begin
                              rx_wr_en    = 1'b1;
                              rx_wr_data  = gather_in;
                              rx_level_in = rx_level_ff + 1'b1;
                           end
                           next_done = done_ff + 1'b1;
                           done_in   = next_done;
                           do_next   = 1'b1;
                        end
                     end
                  end
               end
            end
            smf_pkg::MODE_READ: begin
               unique case (address)
                  smf_pkg::REG_RX_DATA: begin
                     if (rx_level_ff != '0) begin
                        rx_rd_en     = 1'b1;
                        rdata_ram_in = 1'b1;
                        rx_head_in   = wrap_inc(rx_head_ff);
                        rx_level_in  = rx_level_ff - 1'b1;
                     end
                  end
                  smf_pkg::REG_CONTROL:  rdata_in = 32'(control_ff);
                  smf_pkg::REG_IRQ_EN:   rdata_in = irq_enable_ff;
                  smf_pkg::REG_IRQ_STAT: rdata_in = 32'(tc_ff) << smf_pkg::STA_TC;
                  smf_pkg::REG_CLOCK:    rdata_in = 32'(clock_ctl_ff);
                  smf_pkg::REG_BURST:    rdata_in = 32'(burst_ff);
                  smf_pkg::REG_TRANSMIT: rdata_in = 32'(transmit_ff);
                  smf_pkg::REG_FIFO_STAT: begin
                     rdata_in = {9'd0, 7'(tx_level_ff), 9'd0, 7'(rx_level_ff)};
                  end
                  default: rdata_in = '0;
               endcase
            end
            smf_pkg::MODE_WRITE: begin
               unique case (address)
                  smf_pkg::REG_TX_DATA: begin
                     if (tx_level_ff < LW'(DEPTH)) begin
                        tx_wr_en    = 1'b1;
                        tx_level_in = tx_level_ff + 1'b1;
                     end
                  end
                  smf_pkg::REG_CONTROL: begin
                     if (v[smf_pkg::CTL_TF_RST]) begin
                        tx_level_in = '0;
                        tx_head_in  = '0;
                     end
                     if (v[smf_pkg::CTL_RF_RST]) begin
                        rx_level_in = '0;
                        rx_head_in  = '0;
                     end
                     v[smf_pkg::CTL_TF_RST] = 1'b0;
                     v[smf_pkg::CTL_RF_RST] = 1'b0;
                     if (control_ff[smf_pkg::CTL_XCH]) begin
                        v[smf_pkg::CTL_XCH] = 1'b1;
                     end else if (v[smf_pkg::CTL_XCH]) begin
                        next_done = '0;
                        done_in   = '0;
                        do_next   = 1'b1;
                     end
                     control_in = v;
                  end
                  smf_pkg::REG_IRQ_EN:   irq_enable_in = wdata;
                  smf_pkg::REG_IRQ_STAT: tc_in = tc_ff & ~wdata[smf_pkg::STA_TC];
                  smf_pkg::REG_CLOCK:    clock_ctl_in = wdata[smf_pkg::CLK_W-1:0];
                  smf_pkg::REG_BURST:    burst_in = wdata[smf_pkg::COUNT_W-1:0];
                  smf_pkg::REG_TRANSMIT: transmit_in = wdata[smf_pkg::COUNT_W-1:0];
                  default: ;
               endcase
            end
            default: ;
         endcase

         // load the next byte or close the burst
         if (do_next) begin
            bit_in       = '0;
            phase_in     = 1'b0;
            div_in       = '0;
            gather_in    = '0;
            shift_ram_in = 1'b0;
            if (next_done >= burst_in) begin
               control_in[smf_pkg::CTL_XCH] = 1'b0;
               tc_in = 1'b1;
            end else if (next_done < transmit_in && tx_level_in != '0) begin
               tx_rd_en     = 1'b1;
               shift_ram_in = 1'b1;
               tx_head_in   = wrap_inc(tx_head_in);
               tx_level_in  = tx_level_in - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff    <= '0;
         irq_enable_ff <= '0;
         tc_ff         <= 1'b0;
         clock_ctl_ff  <= '0;
         burst_ff      <= '0;
         transmit_ff   <= '0;
         done_ff       <= '0;
         shift_ram_ff  <= 1'b0;
         bit_ff        <= '0;
         div_ff        <= '0;
         phase_ff      <= 1'b0;
         gather_ff     <= '0;
         tx_level_ff   <= '0;
         tx_head_ff    <= '0;
         rx_level_ff   <= '0;
         rx_head_ff    <= '0;
         out_valid_ff  <= 1'b0;
         rdata_ram_ff  <= 1'b0;
      end else begin
         control_ff    <= control_in;
         irq_enable_ff <= irq_enable_in;
         tc_ff         <= tc_in;
         clock_ctl_ff  <= clock_ctl_in;
         burst_ff      <= burst_in;
         transmit_ff   <= transmit_in;
         done_ff       <= done_in;
         shift_ram_ff  <= shift_ram_in;
         bit_ff        <= bit_in;
         div_ff        <= div_in;
         phase_ff      <= phase_in;
         gather_ff     <= gather_in;
         tx_level_ff   <= tx_level_in;
         tx_head_ff    <= tx_head_in;
         rx_level_ff   <= rx_level_in;
         rx_head_ff    <= rx_head_in;
         out_valid_ff  <= out_valid_in;
         rdata_ram_ff  <= rdata_ram_in;
      end
      rdata_ff <= rdata_in;
   end

   smf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wr_addr),
      .wr_data (tx_wr_data),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_head_ff),
      .rd_data (tx_q)
   );

   smf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_addr),
      .wr_data (rx_wr_data),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_head_ff),
      .rd_data (rx_q)
   );

   // the engine state only moves on an accepted beat, so the pins always
   // describe the state after the beat now held in the response register
   always_comb begin
      line_state.busy      = control_ff[smf_pkg::CTL_XCH];
      line_state.cpol      = control_ff[smf_pkg::CTL_CPOL];
      line_state.cpha      = control_ff[smf_pkg::CTL_CPHA];
      line_state.lsb       = control_ff[smf_pkg::CTL_LSB];
      line_state.cs_low    = control_ff[smf_pkg::CTL_CS_LOW];
      line_state.cs_manual = control_ff[smf_pkg::CTL_CS_MANUAL];
      line_state.cs_level  = control_ff[smf_pkg::CTL_CS_LEVEL];
      line_state.cs_sel    = control_ff[smf_pkg::CTL_CS_LO+1:smf_pkg::CTL_CS_LO];
      line_state.phase     = phase_ff;
      line_state.bit_idx   = bit_ff[2:0];
      line_state.shift     = shift_ram_ff ? tx_q : 8'd0;
   end

   smf_pins u_pins (
      .line_state (line_state),
      .pins       (pins)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {control_ff[smf_pkg::CTL_XCH],
                        tc_ff & irq_enable_ff[smf_pkg::STA_TC],
                        pins.cs, pins.mosi, pins.sclk,
                        rdata_ram_ff ? {24'd0, rx_q} : rdata_ff};

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the SPI master with byte FIFOs: register, FIFO and burst tests.
`timescale 1ns / 1ps
module testbench;

   localparam bit [31:0] CTL_MASK   = 32'h0007_ffff;
   localparam bit [31:0] COUNT_MASK = 32'h00ff_ffff;
   localparam int        CYCLE_LIMIT = 400000;
   localparam int        HOLD_CYCLES = 80;
   localparam bit [5:0]  REG_DMA     = 6'h14;
   localparam bit [5:0]  REG_UNKNOWN = 6'h3f;

   typedef struct {
      bit [31:0] read_data;
      bit        sclk;
      bit        mosi;
      bit [3:0]  cs;
      bit        irq;
      bit        busy;
   } pin_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = smf_pkg::MODE_TICK;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   spi_master_fifo_controller_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   pin_beat_type pending_beats[$];
   int  errors = 0;
   int  beats_sent = 0;
   int  beats_checked = 0;
   int  bursts_done = 0;
   int  cycles = 0;
   bit  idle_on = 1'b1;
   int  hold_requests = 0;
   int  hold_served = 0;
   int  hold_left = 0;
   int  stall_left = 0;

   // shadow of the block's state
   bit [7:0]  tx_mem[smf_pkg::FIFO_DEPTH];
   bit [7:0]  rx_mem[smf_pkg::FIFO_DEPTH];
   int        tx_lvl, rx_lvl, tx_hd, rx_hd;
   bit [31:0] ctl, ien, ista, clkc, burst_cnt, xmit_cnt, done_cnt;
   bit [31:0] shift_byte, bit_pos, div_cnt, phase, gather;

   function bit [7:0] tx_take();
      bit [7:0] v;
      if (tx_lvl == 0) return 8'd0;
      v = tx_mem[tx_hd];
      tx_hd = (tx_hd + 1) % smf_pkg::FIFO_DEPTH;
      tx_lvl--;
      return v;
   endfunction

   function bit [7:0] rx_take();
      bit [7:0] v;
      if (rx_lvl == 0) return 8'd0;
      v = rx_mem[rx_hd];
      rx_hd = (rx_hd + 1) % smf_pkg::FIFO_DEPTH;
      rx_lvl--;
      return v;
   endfunction

   task load_next_byte();
      bit_pos = 0;
      phase = 0;
      div_cnt = 0;
      gather = 0;
      if (done_cnt >= burst_cnt) begin
         ctl[smf_pkg::CTL_XCH] = 1'b0;
         ista[smf_pkg::STA_TC] = 1'b1;
         shift_byte = 0;
         bursts_done++;
         return;
      end
      shift_byte = (done_cnt < xmit_cnt) ? tx_take() : 8'd0;
   endtask

   task shift_in(input bit m);
      if (ctl[smf_pkg::CTL_LSB]) gather = (gather >> 1) | (32'(m) << 7);
      else gather = ((gather << 1) | 32'(m)) & 32'hff;
   endtask

   task serial_tick(input bit m);
      int half;
      if (!ctl[smf_pkg::CTL_XCH]) return;
      if (clkc[smf_pkg::CLK_DRS]) half = int'(clkc[7:0]) + 1;
      else half = 1 << clkc[11:8];
      div_cnt++;
      if (div_cnt < half) return;
      div_cnt = 0;
      if (phase == 0) begin
         phase = 1;
         if (!ctl[smf_pkg::CTL_CPHA]) shift_in(m);
         return;
      end
      phase = 0;
      if (ctl[smf_pkg::CTL_CPHA]) shift_in(m);
      bit_pos++;
      if (bit_pos < 8) return;
      if (!(ctl[smf_pkg::CTL_DHB] && done_cnt < xmit_cnt)
          && rx_lvl < smf_pkg::FIFO_DEPTH) begin
         rx_mem[(rx_hd + rx_lvl) % smf_pkg::FIFO_DEPTH] = gather[7:0];
         rx_lvl++;
      end
      done_cnt = (done_cnt + 1) & COUNT_MASK;
      load_next_byte();
   endtask

   task control_store(input bit [31:0] v);
      bit was_busy;
      was_busy = ctl[smf_pkg::CTL_XCH];
      v &= CTL_MASK;
      if (v[smf_pkg::CTL_TF_RST]) begin
         tx_lvl = 0;
         tx_hd = 0;
      end
      if (v[smf_pkg::CTL_RF_RST]) begin
         rx_lvl = 0;
         rx_hd = 0;
      end
      v[smf_pkg::CTL_TF_RST] = 1'b0;
      v[smf_pkg::CTL_RF_RST] = 1'b0;
      if (was_busy) begin
         ctl = v;
         ctl[smf_pkg::CTL_XCH] = 1'b1;
         return;
      end
      ctl = v;
      if (v[smf_pkg::CTL_XCH]) begin
         done_cnt = 0;
         load_next_byte();
      end
   endtask

   task spi_predict(input bit [1:0] md, input bit [5:0] ad, input bit [31:0] wd,
                    input bit mi);
      pin_beat_type b;
      bit [2:0]  bn;
      bit        inact;
      bit        lvl;
      b.read_data = 0;
      b.mosi = 0;
      if (md == smf_pkg::MODE_TICK) serial_tick(mi);
      else if (md == smf_pkg::MODE_READ) begin
         case (ad)
            smf_pkg::REG_RX_DATA:   b.read_data = 32'(rx_take());
            smf_pkg::REG_CONTROL:   b.read_data = ctl;
            smf_pkg::REG_IRQ_EN:    b.read_data = ien;
            smf_pkg::REG_IRQ_STAT:  b.read_data = ista;
            smf_pkg::REG_CLOCK:     b.read_data = clkc;
            smf_pkg::REG_BURST:     b.read_data = burst_cnt;
            smf_pkg::REG_TRANSMIT:  b.read_data = xmit_cnt;
            smf_pkg::REG_FIFO_STAT:
               b.read_data = (rx_lvl & 32'h7f) | ((tx_lvl & 32'h7f) << 16);
            default:       b.read_data = 0;
         endcase
      end else if (md == smf_pkg::MODE_WRITE) begin
         case (ad)
            smf_pkg::REG_TX_DATA: if (tx_lvl < smf_pkg::FIFO_DEPTH) begin
               tx_mem[(tx_hd + tx_lvl) % smf_pkg::FIFO_DEPTH] = wd[7:0];
               tx_lvl++;
            end
            smf_pkg::REG_CONTROL:  control_store(wd);
            smf_pkg::REG_IRQ_EN:   ien = wd;
            smf_pkg::REG_IRQ_STAT: ista &= ~wd;
            smf_pkg::REG_CLOCK:    clkc = wd & 32'h1fff;
            smf_pkg::REG_BURST:    burst_cnt = wd & COUNT_MASK;
            smf_pkg::REG_TRANSMIT: xmit_cnt = wd & COUNT_MASK;
            default: ;
         endcase
      end
      b.busy = ctl[smf_pkg::CTL_XCH];
      b.sclk = ctl[smf_pkg::CTL_CPOL];
      if (b.busy) begin
         b.sclk ^= phase[0];
         bn = bit_pos[2:0];
         if (ctl[smf_pkg::CTL_CPHA] && phase == 0 && bn > 0) bn--;
         b.mosi = ctl[smf_pkg::CTL_LSB] ? shift_byte[bn] : shift_byte[7 - bn];
      end
      inact = ctl[smf_pkg::CTL_CS_LOW];
      b.cs = inact ? 4'hf : 4'h0;
      if (ctl[smf_pkg::CTL_CS_MANUAL]) lvl = ctl[smf_pkg::CTL_CS_LEVEL];
      else lvl = b.busy ? ~inact : inact;
      b.cs[ctl[13:12]] = lvl;
      b.irq = (ista & ien) != 0;
      pending_beats.push_back(b);
   endtask

   // caller stands at a rising edge
   task automatic send_beat(input bit [1:0] md, input bit [5:0] ad, input bit [31:0] wd,
                            input bit mi);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= md;
      req_tdata <= {1'b0, mi, wd, ad};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      spi_predict(md, ad, wd, mi);
      beats_sent++;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task reg_write(input bit [5:0] ad, input bit [31:0] wd);
      send_beat(smf_pkg::MODE_WRITE, ad, wd, 1'($urandom));
   endtask

   task reg_read(input bit [5:0] ad);
      send_beat(smf_pkg::MODE_READ, ad, $urandom, 1'($urandom));
   endtask

   task wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_beats.size() != 0);
   endtask

   // one burst: set divider and counts, fill TX, start, tick to the end, then read FIFO status and RX
   task run_burst(input int nbytes, input int ntx, input int pushes, input bit fastest);
      bit [31:0] c;
      int        k;
      if (fastest) reg_write(smf_pkg::REG_CLOCK, 32'h1000);
      else if ($urandom_range(0, 1))
         reg_write(smf_pkg::REG_CLOCK, 32'h1000 | $urandom_range(0, 2));
      else reg_write(smf_pkg::REG_CLOCK, $urandom_range(0, 1) << 8);
      reg_write(smf_pkg::REG_BURST, nbytes);
      reg_write(smf_pkg::REG_TRANSMIT, ntx);
      for (k = 0; k < pushes; k++) reg_write(smf_pkg::REG_TX_DATA, $urandom);
      c = $urandom & CTL_MASK;
      c[smf_pkg::CTL_TF_RST] = ($urandom_range(0, 7) == 0);
      c[smf_pkg::CTL_RF_RST] = ($urandom_range(0, 3) == 0);
      c[smf_pkg::CTL_XCH] = 1'b1;
      reg_write(smf_pkg::REG_CONTROL, c);
      while (ctl[smf_pkg::CTL_XCH]) begin
         k = $urandom_range(0, 59);
         if (k == 0) begin
            // XCH clear in the value: the burst must keep running
            c = $urandom & CTL_MASK;
            c[smf_pkg::CTL_XCH] = 1'b0;
            c[smf_pkg::CTL_TF_RST] = 1'b0;
            reg_write(smf_pkg::REG_CONTROL, c);
         end else if (k < 4) reg_read(6'($urandom_range(0, 10) * 4));
         else if (k == 4) reg_write(smf_pkg::REG_TX_DATA, $urandom);
         else send_beat(smf_pkg::MODE_TICK, 6'($urandom), $urandom, 1'($urandom));
      end
      reg_read(smf_pkg::REG_FIFO_STAT);
      for (k = $urandom_range(0, nbytes + 1); k > 0; k--) reg_read(smf_pkg::REG_RX_DATA);
   endtask

   task noise_beat();
      bit [5:0]  ad;
      bit [31:0] wd;
      ad = 6'($urandom);
      wd = $urandom;
      case ($urandom_range(0, 2))
         0: send_beat(smf_pkg::MODE_TICK, ad, wd, 1'($urandom));
         1: send_beat(smf_pkg::MODE_READ, ad, wd, 1'($urandom));
         default: begin
            // keep bursts short and dividers fast enough to finish
            if (ad == smf_pkg::REG_CONTROL) wd[smf_pkg::CTL_XCH] = 1'b0;
            if ((ad == smf_pkg::REG_BURST || ad == smf_pkg::REG_CLOCK)
                && ctl[smf_pkg::CTL_XCH]) ad = smf_pkg::REG_IRQ_EN;
            send_beat(smf_pkg::MODE_WRITE, ad, wd, 1'($urandom));
         end
      endcase
   endtask

   task test_reset_values();
      int k;
      for (k = 0; k <= 10; k++) reg_read(6'(k * 4));
   endtask

   task test_register_extremes();
      reg_write(smf_pkg::REG_IRQ_EN, 32'hffff_ffff);
      reg_write(smf_pkg::REG_CLOCK, 32'hffff_ffff);
      reg_write(smf_pkg::REG_BURST, 32'hffff_ffff);
      reg_write(smf_pkg::REG_TRANSMIT, 32'hffff_ffff);
      reg_write(smf_pkg::REG_CONTROL, 32'hffff_fbff);
      reg_read(smf_pkg::REG_CLOCK);
      reg_read(smf_pkg::REG_BURST);
      reg_read(smf_pkg::REG_TRANSMIT);
      reg_read(smf_pkg::REG_CONTROL);
      reg_write(smf_pkg::REG_CONTROL, 32'h0);
      reg_write(REG_DMA, 32'hffff_ffff);
      reg_read(REG_DMA);
      reg_read(REG_UNKNOWN);
   endtask

   task test_zero_burst();
      reg_write(smf_pkg::REG_BURST, 32'h0);
      reg_write(smf_pkg::REG_CONTROL, 32'h1 << smf_pkg::CTL_XCH);
      reg_read(smf_pkg::REG_IRQ_STAT);
      reg_write(smf_pkg::REG_IRQ_STAT, 32'hffff_ffff);
      reg_read(smf_pkg::REG_RX_DATA);
   endtask

   // overfill TX, then a short burst and drain past RX empty
   task test_fifo_limits();
      int k;
      reg_write(smf_pkg::REG_CONTROL, 32'h1 << smf_pkg::CTL_TF_RST);
      run_burst(4, 4, smf_pkg::FIFO_DEPTH + 2, 1'b1);
      wait_drained();
      reg_read(smf_pkg::REG_FIFO_STAT);
      for (k = 0; k < 6; k++) reg_read(smf_pkg::REG_RX_DATA);
   endtask

   task test_backpressure();
      int k;
      hold_requests++;
      for (k = 0; k < 20; k++) noise_beat();
      wait_drained();
   endtask

   task test_random_mix(input int target);
      while (beats_sent < target) begin
         if ($urandom_range(0, 3) != 0)
            run_burst($urandom_range(1, 3), $urandom_range(0, 3), $urandom_range(0, 4), 1'b0);
         else repeat ($urandom_range(3, 12)) noise_beat();
      end
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: long hold on request, else short random stalls
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else rsp_tready <= 1'b1;
   end

   // compare each accepted result beat with the oldest prediction
   always @(negedge clock) begin
      pin_beat_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_beats.size() == 0) begin
            $error("result beat with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            e = pending_beats.pop_front();
            beats_checked++;
            if (rsp_tdata[31:0] !== e.read_data) begin
               $error("read_data expected %h actual %h", e.read_data, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[32] !== e.sclk) begin
               $error("sclk expected %b actual %b", e.sclk, rsp_tdata[32]);
               errors++;
            end
            if (rsp_tdata[33] !== e.mosi) begin
               $error("mosi expected %b actual %b", e.mosi, rsp_tdata[33]);
               errors++;
            end
            if (rsp_tdata[37:34] !== e.cs) begin
               $error("chip_selects expected %h actual %h", e.cs, rsp_tdata[37:34]);
               errors++;
            end
            if (rsp_tdata[38] !== e.irq) begin
               $error("irq expected %b actual %b", e.irq, rsp_tdata[38]);
               errors++;
            end
            if (rsp_tdata[39] !== e.busy) begin
               $error("busy_res expected %b actual %b", e.busy, rsp_tdata[39]);
               errors++;
            end
         end
      end
   end

   initial begin
      tx_lvl = 0; rx_lvl = 0; tx_hd = 0; rx_hd = 0;
      ctl = 0; ien = 0; ista = 0; clkc = 0;
      burst_cnt = 0; xmit_cnt = 0; done_cnt = 0;
      shift_byte = 0; bit_pos = 0; div_cnt = 0; phase = 0; gather = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_register_extremes();
      test_zero_burst();
      wait_drained();
      test_fifo_limits();
      test_backpressure();
      test_random_mix(500);
      wait_drained();
      idle_on = 1'b0;
      test_random_mix(620);
      wait_drained();
      repeat (8) @(posedge clock);
      if (pending_beats.size() != 0) begin
         $error("%0d result beats never arrived", pending_beats.size());
         errors++;
      end
      $display("covered %0d beats checked, %0d bursts completed, TX fill and overrun,",
               beats_checked, bursts_done);
      $display("zero-length burst, register extremes, long output hold and drain pauses");
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
